@@ rtl/wli_pkg.sv @@
// Shared types and constants for the waypoint linear interpolator.
package wli_pkg;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_SAMPLE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  localparam int TIME_BITS  = 32;
  localparam int RATIO_BITS = 17;
  localparam logic [RATIO_BITS-1:0] RATIO_ONE = 17'h10000;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_READ,
    BK_DIV,
    BK_BLEND,
    BK_EMIT
  } bk_state_t;

endpackage

@@ rtl/wli_front.sv @@
// Front end: accepts commands and queues them for the back end.
module wli_front
  import wli_pkg::*;
#(
  parameter int JOINTS   = 6,
  parameter int POS_BITS = 16,
  parameter int QDEPTH   = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_mode,
  input  logic [TIME_BITS-1:0]              in_time,
  input  logic [JOINTS*POS_BITS-1:0]        in_pos,
  output logic                              q_valid,
  input  logic                              q_pop,
  output logic [1:0]                        q_mode,
  output logic [TIME_BITS-1:0]              q_time,
  output logic [JOINTS*POS_BITS-1:0]        q_pos
);

  localparam int QW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  logic [1:0]                 mode_q [QDEPTH];
  logic [TIME_BITS-1:0]       time_q [QDEPTH];
  logic [JOINTS*POS_BITS-1:0] pos_q  [QDEPTH];
  logic [QW-1:0]              wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QW:0]                cnt_r, cnt_nxt;
  logic                       push;

  assign busy    = (cnt_r == (QW+1)'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_mode  = mode_q[rd_r];
  assign q_time  = time_q[rd_r];
  assign q_pos   = pos_q[rd_r];

  // advance pointers and count
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QW'(QDEPTH-1)) ? '0 : wr_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rd_nxt = (rd_r == QW'(QDEPTH-1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !(q_pop && q_valid)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop && q_valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold queued items
  always_ff @(posedge clk) begin
    if (push) begin
      mode_q[wr_r] <= in_mode;
      time_q[wr_r] <= in_time;
      pos_q[wr_r]  <= in_pos;
    end
  end

endmodule

@@ rtl/wli_div.sv @@
// Restoring divider for the segment ratio, one quotient bit a cycle.
module wli_div
  import wli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [TIME_BITS-1:0]  num,
  input  logic [TIME_BITS-1:0]  den,
  output logic                  done,
  output logic [RATIO_BITS-1:0] ratio
);

  // numerator is num << 16; quotient clamped to 17 bits
  localparam int NB = TIME_BITS + 16;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0]        n_r, n_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [NB-1:0]        q_r, q_nxt;
  logic [TIME_BITS-1:0] d_r;
  logic [CW-1:0]        c_r, c_nxt;
  logic                 run_r, run_nxt, done_r, done_nxt;
  logic [TIME_BITS:0]   sh;

  // shift one numerator bit in and try to subtract
  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    c_nxt    = c_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    sh       = {rem_r, n_r[NB-1]};
    if (go) begin
      n_nxt   = {num, 16'h0};
      rem_nxt = '0;
      q_nxt   = '0;
      c_nxt   = CW'(NB);
      run_nxt = 1'b1;
    end else if (run_r) begin
      n_nxt = {n_r[NB-2:0], 1'b0};
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = TIME_BITS'(sh - {1'b0, d_r});
        q_nxt   = {q_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = sh[TIME_BITS-1:0];
        q_nxt   = {q_r[NB-2:0], 1'b0};
      end
      c_nxt = c_r - 1'b1;
      if (c_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      c_r    <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      c_r    <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (go) begin
      d_r <= den;
    end
  end

  assign done  = done_r;
  assign ratio = (q_r > NB'(RATIO_ONE)) ? RATIO_ONE : q_r[RATIO_BITS-1:0];

endmodule

@@ rtl/wli_back.sv @@
// Back end: waypoint tables, segment search, ratio division and joint blending.
module wli_back
  import wli_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int JOINTS     = 6,
  parameter int POS_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  logic [1:0]                 q_mode,
  input  logic [TIME_BITS-1:0]       q_time,
  input  logic [JOINTS*POS_BITS-1:0] q_pos,
  output logic                       out_strobe,
  output logic [JOINTS*POS_BITS-1:0] out_pos,
  output logic                       out_finished
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int DW = POS_BITS + 1;
  localparam int PW = DW + RATIO_BITS;

  // waypoint memories
  logic [TIME_BITS-1:0]       tmem [MAX_POINTS];
  logic [JOINTS*POS_BITS-1:0] pmem [MAX_POINTS];
  logic [TIME_BITS-1:0]       trd_r;
  logic [JOINTS*POS_BITS-1:0] prd_r;
  logic [AW-1:0]              raddr;

  logic [JOINTS*POS_BITS-1:0] start_r;
  logic [CNTW-1:0]            cnt_r;

  bk_state_t                  st_r, st_nxt;
  logic [TIME_BITS-1:0]       t_r;
  logic [CNTW-1:0]            idx_r, idx_nxt;
  logic [TIME_BITS-1:0]       tprev_r, tprev_nxt;
  logic                       fin_r, fin_nxt;
  logic [JOINTS*POS_BITS-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [JOINTS*POS_BITS-1:0] res_r, res_nxt;
  logic [JW-1:0]              j_r, j_nxt;
  logic                       ostb_r, ostb_nxt;

  logic                       div_go;
  logic                       div_done;
  logic [RATIO_BITS-1:0]      ratio;
  logic [RATIO_BITS-1:0]      ratio_r, ratio_nxt;
  logic [TIME_BITS-1:0]       div_num, div_den;

  logic signed [POS_BITS-1:0] ja, jb;
  logic signed [DW-1:0]       diff;
  logic signed [PW-1:0]       prod_r;
  logic                       prod_v_r;
  logic signed [PW-1:0]       blended;

  wli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .ratio (ratio)
  );

  assign raddr = idx_r[AW-1:0];

  // write on append, read at the search index
  always_ff @(posedge clk) begin
    if (q_pop && q_mode == MODE_APPEND && cnt_r < CNTW'(MAX_POINTS)) begin
      tmem[cnt_r[AW-1:0]] <= q_time;
      pmem[cnt_r[AW-1:0]] <= q_pos;
    end
    trd_r <= tmem[raddr];
    prd_r <= pmem[raddr];
  end

  // store start positions and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      cnt_r   <= '0;
    end else if (q_pop) begin
      unique case (mode_t'(q_mode))
        MODE_START:  start_r <= q_pos;
        MODE_APPEND: if (cnt_r < CNTW'(MAX_POINTS)) cnt_r <= cnt_r + 1'b1;
        MODE_CLEAR:  cnt_r <= '0;
        MODE_SAMPLE: ;
        default:     ;
      endcase
    end
  end

  assign ja      = pa_r[j_r*POS_BITS +: POS_BITS];
  assign jb      = pb_r[j_r*POS_BITS +: POS_BITS];
  assign diff    = DW'(jb) - DW'(ja);
  assign blended = PW'(ja) + (prod_r >>> 16);
  assign div_num = t_r - tprev_r;
  assign div_den = trd_r - tprev_r;

  // sequencer: search (read then compare), divide, blend one joint at a time
  always_comb begin
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    tprev_nxt = tprev_r;
    fin_nxt   = fin_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    res_nxt   = res_r;
    j_nxt     = j_r;
    ratio_nxt = ratio_r;
    ostb_nxt  = 1'b0;
    q_pop     = 1'b0;
    div_go    = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_mode == MODE_SAMPLE) begin
            idx_nxt   = '0;
            tprev_nxt = '0;
            pa_nxt    = start_r;
            if (cnt_r == '0) begin
              res_nxt = start_r;
              fin_nxt = 1'b0;
              st_nxt  = BK_EMIT;
            end else begin
              st_nxt = BK_READ;
            end
          end
        end
      end
      BK_READ: begin
        st_nxt = BK_SEARCH;
      end
      BK_SEARCH: begin
        if (t_r <= trd_r) begin
          pb_nxt = prd_r;
          fin_nxt = (idx_r == cnt_r - 1'b1) && (t_r >= trd_r);
          if (trd_r <= tprev_r) begin
            ratio_nxt = RATIO_ONE;
            j_nxt = '0;
            st_nxt = BK_BLEND;
          end else if (t_r <= tprev_r) begin
            ratio_nxt = '0;
            j_nxt = '0;
            st_nxt = BK_BLEND;
          end else begin
            div_go = 1'b1;
            st_nxt = BK_DIV;
          end
        end else if (idx_r == cnt_r - 1'b1) begin
          res_nxt = prd_r;
          fin_nxt = 1'b1;
          st_nxt  = BK_EMIT;
        end else begin
          tprev_nxt = trd_r;
          pa_nxt    = prd_r;
          idx_nxt   = idx_r + 1'b1;
          st_nxt    = BK_READ;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          ratio_nxt = ratio;
          j_nxt = '0;
          st_nxt = BK_BLEND;
        end
      end
      BK_BLEND: begin
        if (prod_v_r) begin
          res_nxt[j_r*POS_BITS +: POS_BITS] = blended[POS_BITS-1:0];
          if (j_r == JW'(JOINTS-1)) begin
            st_nxt = BK_EMIT;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      BK_EMIT: begin
        ostb_nxt = 1'b1;
        st_nxt   = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // multiply one joint at a time; prod_v_r marks each registered product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= (st_r == BK_BLEND) && !prod_v_r;
    end
    prod_r <= diff * $signed({1'b0, ratio_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      ostb_r <= 1'b0;
      idx_r  <= '0;
      j_r    <= '0;
    end else begin
      st_r   <= st_nxt;
      ostb_r <= ostb_nxt;
      idx_r  <= idx_nxt;
      j_r    <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) t_r <= q_time;
    tprev_r <= tprev_nxt;
    fin_r   <= fin_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    res_r   <= res_nxt;
    ratio_r <= ratio_nxt;
  end

  assign out_strobe   = ostb_r;
  assign out_pos      = res_r;
  assign out_finished = fin_r;

endmodule

@@ rtl/waypoint_linear_interpolator.sv @@
// Top level of the waypoint linear interpolator.
//
//  channel | ports                                 | handshake
//  input   | in_mode, in_time_value, in_pos_a..f    | start && !busy
//  result  | out_cmd_a..f, out_finished            | out_valid, one cycle
//
// A command enters a two-entry queue; the back end takes one at a time.
// Set, append and clear are done when popped; a sample walks the table through
// the read and search states per waypoint, then runs the bit-serial ratio divide
// and blends the joints one at a time; an empty table, a past-the-end or a degenerate case skips the divide.
// Reset clears start positions and the count; table entries are not cleared.
// The receiver cannot stall: each result shows for one cycle.
module waypoint_linear_interpolator
  import wli_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [31:0]         in_time_value,
  input  logic signed [15:0]  in_pos_a,
  input  logic signed [15:0]  in_pos_b,
  input  logic signed [15:0]  in_pos_c,
  input  logic signed [15:0]  in_pos_d,
  input  logic signed [15:0]  in_pos_e,
  input  logic signed [15:0]  in_pos_f,
  output logic                out_valid,
  output logic signed [15:0]  out_cmd_a,
  output logic signed [15:0]  out_cmd_b,
  output logic signed [15:0]  out_cmd_c,
  output logic signed [15:0]  out_cmd_d,
  output logic signed [15:0]  out_cmd_e,
  output logic signed [15:0]  out_cmd_f,
  output logic                out_finished
);

  localparam int JOINTS = 6;
  localparam int PB     = 16;

  logic               q_valid, q_pop;
  logic [1:0]         q_mode;
  logic [31:0]        q_time;
  logic [JOINTS*PB-1:0] q_pos, o_pos;

  wli_front #(.JOINTS(JOINTS), .POS_BITS(PB), .QDEPTH(2)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_mode (in_mode),
    .in_time (in_time_value),
    .in_pos  ({in_pos_f, in_pos_e, in_pos_d, in_pos_c, in_pos_b, in_pos_a}),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_mode  (q_mode),
    .q_time  (q_time),
    .q_pos   (q_pos)
  );

  wli_back #(.MAX_POINTS(MAX_POINTS), .JOINTS(JOINTS), .POS_BITS(PB)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_mode       (q_mode),
    .q_time       (q_time),
    .q_pos        (q_pos),
    .out_strobe   (out_valid),
    .out_pos      (o_pos),
    .out_finished (out_finished)
  );

  assign out_cmd_a = o_pos[0*PB +: PB];
  assign out_cmd_b = o_pos[1*PB +: PB];
  assign out_cmd_c = o_pos[2*PB +: PB];
  assign out_cmd_d = o_pos[3*PB +: PB];
  assign out_cmd_e = o_pos[4*PB +: PB];
  assign out_cmd_f = o_pos[5*PB +: PB];

  // the result strobe is never held high past its pulse
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // nothing is popped without an entry
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // no result in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

endmodule

@@ tb/waypoint_linear_interpolator_tb.sv @@
// Self-checking testbench for the waypoint linear interpolator.
module waypoint_linear_interpolator_tb;
  import wli_pkg::*;

  localparam int NPTS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    mode_t              mode;
    logic [31:0]        tval;
    logic signed [15:0] p0, p1, p2, p3, p4, p5;
  } cmd_item_t;

  typedef struct packed {
    logic signed [15:0] c0, c1, c2, c3, c4, c5;
    logic               fin;
  } sample_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = '0;
  logic [31:0] in_time_value = '0;
  logic signed [15:0] in_pos_a = '0, in_pos_b = '0, in_pos_c = '0;
  logic signed [15:0] in_pos_d = '0, in_pos_e = '0, in_pos_f = '0;
  logic out_valid, out_finished;
  logic signed [15:0] out_cmd_a, out_cmd_b, out_cmd_c, out_cmd_d, out_cmd_e, out_cmd_f;

  waypoint_linear_interpolator DUT (.*);

  always #10 clk = ~clk;

  // predictor state
  logic signed [15:0] hold_pos [6] = '{default: '0};
  logic [31:0]        wp_time [NPTS];
  logic signed [15:0] wp_pos [NPTS][6];
  int                 wp_count = 0;

  cmd_item_t   pending_q[$];
  sample_res_t expected_q[$];
  int  errors = 0;
  int  n_samples = 0, n_finished = 0, n_sent = 0;
  bit  hold_off = 1'b0;
  bit  calm = 1'b0;
  bit  all_queued = 1'b0;
  int  idle_cycles = 0;

  // append an item to the stimulus queue
  function automatic void queue_item(cmd_item_t it);
    pending_q = {pending_q, it};
  endfunction

  function automatic logic [16:0] seg_ratio(logic [31:0] t, logic [31:0] s, logic [31:0] e);
    logic [63:0] r;
    if (e <= s) return RATIO_ONE;
    if (t <= s) return '0;
    r = (64'(t - s) << 16) / 64'(e - s);
    return (r > 64'(RATIO_ONE)) ? RATIO_ONE : r[16:0];
  endfunction

  // a + floor((b - a) * ratio / 2^16); arithmetic shift floors
  function automatic logic signed [15:0] mix(logic signed [15:0] a, logic signed [15:0] b,
                                             logic [16:0] r);
    longint prod;
    prod = (longint'(b) - longint'(a)) * longint'(r);
    return 16'(longint'(a) + (prod >>> 16));
  endfunction

  function automatic void predict_item(cmd_item_t it);
    logic signed [15:0] p [6];
    logic signed [15:0] c [6];
    logic [16:0] r;
    logic f;
    bit found;
    sample_res_t res;
    p = '{it.p0, it.p1, it.p2, it.p3, it.p4, it.p5};
    f = 1'b0;
    case (it.mode)
      MODE_START: hold_pos = p;
      MODE_APPEND: begin
        if (wp_count < NPTS) begin
          wp_time[wp_count] = it.tval;
          wp_pos[wp_count] = p;
          wp_count++;
        end
      end
      MODE_CLEAR: wp_count = 0;
      default: begin
        if (wp_count == 0) begin
          c = hold_pos;
        end else if (it.tval <= wp_time[0]) begin
          r = seg_ratio(it.tval, 32'd0, wp_time[0]);
          for (int j = 0; j < 6; j++) c[j] = mix(hold_pos[j], wp_pos[0][j], r);
          f = (wp_count == 1) && (it.tval >= wp_time[0]);
        end else begin
          found = 0;
          for (int i = 1; i < wp_count; i++) begin
            if (!found && it.tval <= wp_time[i]) begin
              r = seg_ratio(it.tval, wp_time[i-1], wp_time[i]);
              for (int j = 0; j < 6; j++) c[j] = mix(wp_pos[i-1][j], wp_pos[i][j], r);
              f = (i == wp_count - 1) && (it.tval >= wp_time[i]);
              found = 1;
            end
          end
          if (!found) begin
            c = wp_pos[wp_count-1];
            f = 1'b1;
          end
        end
        res = '{c[0], c[1], c[2], c[3], c[4], c[5], f};
        expected_q = {expected_q, res};
      end
    endcase
  endfunction

  function automatic logic signed [15:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_item_t make_item(mode_t m, logic [31:0] t);
    cmd_item_t it;
    it = '{m, t, rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos()};
    return it;
  endfunction

  // drive items; hold off at random and on request
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_item(cmd_item_t'({mode_t'(in_mode), in_time_value, in_pos_a, in_pos_b,
                                  in_pos_c, in_pos_d, in_pos_e, in_pos_f}));
        n_sent++;
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && !hold_off && (calm || $urandom_range(0, 99) >= 24)) begin
          cmd_item_t it;
          it = pending_q.pop_front();
          start <= 1'b1;
          in_mode <= it.mode;
          in_time_value <= it.tval;
          in_pos_a <= it.p0; in_pos_b <= it.p1; in_pos_c <= it.p2;
          in_pos_d <= it.p3; in_pos_e <= it.p4; in_pos_f <= it.p5;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && (out_valid || (start && !busy))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: %h", $time,
                 {out_cmd_a, out_cmd_b, out_cmd_c, out_cmd_d, out_cmd_e, out_cmd_f});
        errors++;
      end else begin
        sample_res_t e;
        sample_res_t a;
        e = expected_q.pop_front();
        a = '{out_cmd_a, out_cmd_b, out_cmd_c, out_cmd_d, out_cmd_e, out_cmd_f, out_finished};
        if (a !== e) begin
          $display("%0t: mismatch expected %h %h %h %h %h %h fin=%b", $time,
                   e.c0, e.c1, e.c2, e.c3, e.c4, e.c5, e.fin);
          $display("%0t:          actual   %h %h %h %h %h %h fin=%b", $time,
                   a.c0, a.c1, a.c2, a.c3, a.c4, a.c5, a.fin);
          errors++;
        end
        n_samples++;
        if (a.fin) n_finished++;
      end
    end
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [31:0] tbase;
    int npts;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, zero first time, full table, clear
    queue_item(make_item(MODE_SAMPLE, 32'd0));
    queue_item(make_item(MODE_START, 32'd0));
    queue_item(make_item(MODE_SAMPLE, 32'hffff_ffff));
    queue_item(make_item(MODE_APPEND, 32'd0));
    queue_item(make_item(MODE_SAMPLE, 32'd0));
    queue_item(make_item(MODE_SAMPLE, 32'd5));
    queue_item(make_item(MODE_CLEAR, 32'd0));
    queue_item(cmd_item_t'({MODE_START, 32'd0, 16'sh7fff, 16'sh8000, 16'sh7fff,
                            16'sh8000, 16'sh0000, 16'shffff}));
    queue_item(cmd_item_t'({MODE_APPEND, 32'd1000, 16'sh8000, 16'sh7fff, 16'sh8000,
                            16'sh7fff, 16'shffff, 16'sh0000}));
    queue_item(make_item(MODE_SAMPLE, 32'd333));
    queue_item(make_item(MODE_SAMPLE, 32'd1000));
    queue_item(make_item(MODE_APPEND, 32'd500));
    queue_item(make_item(MODE_APPEND, 32'hffff_ffff));
    queue_item(make_item(MODE_SAMPLE, 32'd1001));
    queue_item(make_item(MODE_SAMPLE, 32'hffff_fffe));
    queue_item(make_item(MODE_SAMPLE, 32'hffff_ffff));
    for (int i = 0; i < 66; i++) queue_item(make_item(MODE_APPEND, 32'(i * 10)));
    queue_item(make_item(MODE_SAMPLE, 32'd635));
    queue_item(make_item(MODE_SAMPLE, 32'd700));
    queue_item(make_item(MODE_CLEAR, 32'd0));
    queue_item(make_item(MODE_SAMPLE, 32'd7));

    // wait until every sample so far has come back
    wait (pending_q.size() == 0 && !start);
    hold_off = 1'b1;
    wait (expected_q.size() == 0);
    repeat (300) @(posedge clk);
    hold_off = 1'b0;

    // random trajectories: mostly increasing times, some noise
    for (int k = 0; k < 60; k++) begin
      calm = (k >= 20 && k < 28);
      queue_item(make_item(MODE_CLEAR, $urandom));
      queue_item(make_item(MODE_START, $urandom));
      npts = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
      tbase = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
      for (int i = 0; i < npts; i++) begin
        if ($urandom_range(0, 9) == 0) tbase = $urandom;
        else tbase = tbase + $urandom_range(0, 3000);
        queue_item(make_item(MODE_APPEND, tbase));
      end
      for (int i = 0; i < 14; i++) begin
        case ($urandom_range(0, 9))
          0: queue_item(make_item(MODE_SAMPLE, $urandom));
          1: queue_item(make_item(MODE_SAMPLE, tbase + $urandom_range(0, 5)));
          2: queue_item(make_item(mode_t'($urandom_range(0, 3)), $urandom));
          default: queue_item(make_item(MODE_SAMPLE, $urandom_range(0, tbase + 100)));
        endcase
      end
      wait (pending_q.size() < 4);
    end
    calm = 1'b0;

    wait (pending_q.size() == 0 && !start);
    wait (expected_q.size() == 0);
    repeat (400) @(posedge clk);
    $display("Sent %0d items; checked %0d samples, %0d of them past the end.",
             n_sent, n_samples, n_finished);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wli_pkg.sv
rtl/wli_front.sv
rtl/wli_div.sv
rtl/wli_back.sv
rtl/waypoint_linear_interpolator.sv
tb/waypoint_linear_interpolator_tb.sv
